FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define CSVT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CSVT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CSVT_ASSERT(lbl, clk, rst_n, prop, msg)
`define CSVT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

FILE: hw/rtl/csvt_pkg.sv
// Types, character codes and helpers for the CSV record tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package csvt_pkg;

    localparam int CuWidth         = 16;
    localparam int ColWidth        = 8;
    localparam int MaxColumnsDef   = 256;

    localparam logic [CuWidth-1:0] ChQuote = 16'h0022;
    localparam logic [CuWidth-1:0] ChComma = 16'h002C;
    localparam logic [CuWidth-1:0] ChCr    = 16'h000D;
    localparam logic [CuWidth-1:0] ChLf    = 16'h000A;

    typedef struct packed {
        logic [CuWidth-1:0] code_unit;
        logic               end_of_text;
    } t_item;

    typedef struct packed {
        logic                char_valid;
        logic [CuWidth-1:0]  out_char;
        logic                field_end;
        logic                record_end;
        logic                record_blank;
        logic [ColWidth-1:0] column_index;
    } t_result;

    // Unicode whitespace code units that do not count as record content.
    function automatic logic f_is_space(input logic [CuWidth-1:0] c);
        logic sp;
        sp = 1'b0;
        if (c >= 16'h0009 && c <= 16'h000D) sp = 1'b1;
        if (c == 16'h0020 || c == 16'h0085 || c == 16'h00A0 || c == 16'h1680) sp = 1'b1;
        if (c >= 16'h2000 && c <= 16'h200A) sp = 1'b1;
        if (c == 16'h2028 || c == 16'h2029 || c == 16'h202F) sp = 1'b1;
        if (c == 16'h205F || c == 16'h3000) sp = 1'b1;
        return sp;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/csvt_ifs.sv
// Valid/ready channel interfaces for code units in and tokens out.
`timescale 1ns / 1ps
`default_nettype none

interface csvt_in_if;
    logic                         valid;
    logic                         ready;
    logic [csvt_pkg::CuWidth-1:0] code_unit;
    logic                         end_of_text;

    modport source (output valid, output code_unit, output end_of_text, input ready);
    modport sink   (input valid, input code_unit, input end_of_text, output ready);
endinterface

interface csvt_out_if;
    logic                          valid;
    logic                          ready;
    logic                          char_valid;
    logic [csvt_pkg::CuWidth-1:0]  out_char;
    logic                          field_end;
    logic                          record_end;
    logic                          record_blank;
    logic [csvt_pkg::ColWidth-1:0] column_index;

    modport source (output valid, output char_valid, output out_char, output field_end,
                    output record_end, output record_blank, output column_index,
                    input ready);
    modport sink   (input valid, input char_valid, input out_char, input field_end,
                    input record_end, input record_blank, input column_index,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/csvt_in_reg.sv
// Input register stage: captures one code unit per transfer.
`timescale 1ns / 1ps
`default_nettype none

module csvt_in_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    csvt_in_if.sink              i_in,
    input  wire logic            i_take,
    output logic                 o_valid,
    output csvt_pkg::t_item      o_item
);
    import csvt_pkg::*;

    logic  r_valid;
    t_item r_item;

    // Refill whenever empty or the held item moves on this cycle.
    assign i_in.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.code_unit   <= i_in.code_unit;
            r_item.end_of_text <= i_in.end_of_text;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

FILE: hw/rtl/csvt_core.sv
// Tokenizer state and single-step next-state / token logic.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module csvt_core #(
    parameter int MAX_COLUMNS = csvt_pkg::MaxColumnsDef
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire csvt_pkg::t_item i_item,
    output csvt_pkg::t_result    o_result
);
    import csvt_pkg::*;

    localparam int ColLimitInt = (MAX_COLUMNS - 1 < 255) ? (MAX_COLUMNS - 1) : 255;
    localparam logic [ColWidth-1:0] ColLimit = ColWidth'(ColLimitInt);

    logic                r_iq, r_qp, r_cr, r_fhc, r_rhf, r_rhc;
    logic [ColWidth-1:0] r_col;
    logic                n_iq, n_qp, n_cr, n_fhc, n_rhf, n_rhc;
    logic [ColWidth-1:0] n_col;

    logic               done;
    logic               iq_now;
    logic               do_emit;
    logic [CuWidth-1:0] emit_char;
    logic               do_close_field;
    logic               do_close_record;
    logic [CuWidth-1:0] c;

    assign c = i_item.code_unit;

    // Decide which actions this unit triggers.
    always_comb begin
        done            = 1'b0;
        iq_now          = r_iq;
        do_emit         = 1'b0;
        emit_char       = c;
        do_close_field  = 1'b0;
        do_close_record = 1'b0;
        n_iq            = r_iq;
        n_qp            = r_qp;
        n_cr            = r_cr;
        if (i_item.end_of_text) begin
            do_close_field  = r_fhc || r_rhf;
            do_close_record = r_fhc || r_rhf;
        end else begin
            if (r_cr) begin
                n_cr = 1'b0;
                if (c == ChLf) done = 1'b1;
            end
            if (!done && r_qp) begin
                n_qp = 1'b0;
                if (c == ChQuote) begin
                    do_emit   = 1'b1;
                    emit_char = ChQuote;
                    done      = 1'b1;
                end else begin
                    n_iq   = 1'b0;
                    iq_now = 1'b0;
                end
            end
            if (!done) begin
                if (iq_now) begin
                    if (c == ChQuote) n_qp = 1'b1;
                    else              do_emit = 1'b1;
                end else if (c == ChQuote) begin
                    n_iq = 1'b1;
                end else if (c == ChComma) begin
                    do_close_field = 1'b1;
                end else if (c == ChCr) begin
                    do_close_field  = 1'b1;
                    do_close_record = 1'b1;
                    n_cr            = 1'b1;
                end else if (c == ChLf) begin
                    do_close_field  = 1'b1;
                    do_close_record = 1'b1;
                end else begin
                    do_emit = 1'b1;
                end
            end
        end
    end

    // Apply the actions to the row bookkeeping and build the token.
    always_comb begin
        n_fhc = r_fhc;
        n_rhf = r_rhf;
        n_rhc = r_rhc;
        n_col = r_col;
        o_result              = '0;
        o_result.column_index = r_col;
        if (do_emit) begin
            o_result.char_valid = 1'b1;
            o_result.out_char   = emit_char;
            n_fhc               = 1'b1;
            if (!f_is_space(emit_char)) n_rhc = 1'b1;
        end
        if (do_close_field) begin
            o_result.field_end = 1'b1;
            n_fhc              = 1'b0;
            n_rhf              = 1'b1;
            if (r_col < ColLimit) n_col = r_col + 1'b1;
        end
        if (do_close_record) begin
            o_result.record_end   = 1'b1;
            o_result.record_blank = !r_rhc;
            n_rhf                 = 1'b0;
            n_rhc                 = 1'b0;
            n_col                 = '0;
        end
        if (i_item.end_of_text) begin
            n_fhc = 1'b0;
            n_rhf = 1'b0;
            n_rhc = 1'b0;
            n_col = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iq  <= 1'b0;
            r_qp  <= 1'b0;
            r_cr  <= 1'b0;
            r_fhc <= 1'b0;
            r_rhf <= 1'b0;
            r_rhc <= 1'b0;
            r_col <= '0;
        end else if (i_step) begin
            r_iq  <= i_item.end_of_text ? 1'b0 : n_iq;
            r_qp  <= i_item.end_of_text ? 1'b0 : n_qp;
            r_cr  <= i_item.end_of_text ? 1'b0 : n_cr;
            r_fhc <= n_fhc;
            r_rhf <= n_rhf;
            r_rhc <= n_rhc;
            r_col <= n_col;
        end
    end

    `CSVT_ASSERT(a_qp_in_quotes, i_clk, i_rst_n, r_qp |-> r_iq, "quote pending outside quotes")
    `CSVT_ASSERT(a_rec_end_col0, i_clk, i_rst_n, (i_step && o_result.record_end) |=> (r_col == '0), "column not cleared after record end")
    `CSVT_ASSERT(a_eot_clears, i_clk, i_rst_n, (i_step && i_item.end_of_text) |=> !(r_iq || r_qp || r_cr || r_fhc || r_rhf || r_rhc), "state not cleared by end of text")
    `CSVT_NEVER(a_rec_needs_field, i_clk, i_rst_n, o_result.record_end && !o_result.field_end, "record closed without field close")

endmodule

`default_nettype wire

FILE: hw/rtl/csvt_out_reg.sv
// Result register: holds one token until the sink takes the transfer.
`timescale 1ns / 1ps
`default_nettype none

module csvt_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire csvt_pkg::t_result i_result,
    output logic                   o_can_load,
    csvt_out_if.source             o_out
);
    import csvt_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Accept a new token when empty or when the held one leaves now.
    assign o_can_load = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.char_valid   = r_result.char_valid;
    assign o_out.out_char     = r_result.out_char;
    assign o_out.field_end    = r_result.field_end;
    assign o_out.record_end   = r_result.record_end;
    assign o_out.record_blank = r_result.record_blank;
    assign o_out.column_index = r_result.column_index;

endmodule

`default_nettype wire

FILE: hw/rtl/csv_record_tokenizer.sv
// Top level of the streaming CSV record tokenizer.
// Path: an input transfer is held in the input register, then stepped into the result register.
// Throughput: one code unit per cycle unless output stalls; the tokenizer state updates in one step.
// Backpressure: the input register and result register keep both sides moving.
// Reset: synchronous active-low i_rst_n empties both stages and clears all flags
// and the column counter; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module csv_record_tokenizer #(
    parameter int MAX_COLUMNS = csvt_pkg::MaxColumnsDef
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    csvt_in_if.sink    i_in,
    csvt_out_if.source o_out
);
    import csvt_pkg::*;

    logic    in_valid;
    t_item   in_item;
    logic    can_load;
    logic    step;
    t_result result;

    // Advance the held unit through the tokenizer when the result slot frees up.
    assign step = in_valid && can_load;

    csvt_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (step),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    // One step per unit: quote, CR and row flags plus the saturating column.
    csvt_core #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (in_item),
        .o_result (result)
    );

    // Hold the token until the output transfer completes.
    csvt_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step),
        .i_result   (result),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

FILE: sim/csv_record_tokenizer_tb.sv
// Self-checking testbench for the CSV record tokenizer: directed and random text streams.
`timescale 1ns / 1ps

// Track tokenizer state, predict one token per accepted transfer and match outputs in order.
class csv_token_scoreboard;
    csvt_pkg::t_result tokens_due[$];
    csvt_pkg::t_result next_tok;

    bit         in_quotes;
    bit         quote_seen;
    bit         cr_seen;
    bit         field_open;
    bit         row_started;
    bit         row_nonblank;
    logic [7:0] column;
    logic [7:0] col_limit;

    int n_errors;
    int n_units;
    int n_eot;
    int n_checked;
    int n_records;
    int n_blank;
    int n_escaped;
    int n_saturated;

    function new(int max_columns);
        col_limit = (max_columns - 1 < 255) ? 8'(max_columns - 1) : 8'd255;
        clear_state();
    endfunction

    function void clear_state();
        in_quotes    = 1'b0;
        quote_seen   = 1'b0;
        cr_seen      = 1'b0;
        field_open   = 1'b0;
        row_started  = 1'b0;
        row_nonblank = 1'b0;
        column       = '0;
    endfunction

    function bit is_blank_unit(logic [15:0] c);
        return (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0020 || c == 16'h0085 ||
               c == 16'h00A0 || c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A) ||
               c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
               c == 16'h3000;
    endfunction

    function void append_unit(logic [15:0] c);
        next_tok.char_valid = 1'b1;
        next_tok.out_char   = c;
        field_open          = 1'b1;
        if (!is_blank_unit(c)) row_nonblank = 1'b1;
    endfunction

    function void end_field();
        next_tok.field_end = 1'b1;
        field_open         = 1'b0;
        row_started        = 1'b1;
        if (column < col_limit) column++;
        else n_saturated++;
    endfunction

    function void end_record();
        next_tok.record_end   = 1'b1;
        next_tok.record_blank = !row_nonblank;
        row_started           = 1'b0;
        row_nonblank          = 1'b0;
        column                = '0;
        n_records++;
        if (!row_nonblank && next_tok.record_blank) n_blank++;
    endfunction

    // Step the tokenizer state for one accepted input transfer and queue its token.
    function void note_unit(logic [15:0] cu, logic eot);
        next_tok              = '0;
        next_tok.column_index = column;
        if (eot) begin
            n_eot++;
            if (field_open || row_started) begin
                end_field();
                end_record();
            end
            clear_state();
        end else begin
            n_units++;
            if (cr_seen && cu == csvt_pkg::ChLf) begin
                cr_seen = 1'b0;
            end else if (quote_seen && cu == csvt_pkg::ChQuote) begin
                cr_seen    = 1'b0;
                quote_seen = 1'b0;
                append_unit(csvt_pkg::ChQuote);
                n_escaped++;
            end else begin
                cr_seen = 1'b0;
                if (quote_seen) begin
                    quote_seen = 1'b0;
                    in_quotes  = 1'b0;
                end
                if (in_quotes) begin
                    if (cu == csvt_pkg::ChQuote) quote_seen = 1'b1;
                    else append_unit(cu);
                end else begin
                    case (cu)
                        csvt_pkg::ChQuote: in_quotes = 1'b1;
                        csvt_pkg::ChComma: end_field();
                        csvt_pkg::ChCr: begin
                            end_field();
                            end_record();
                            cr_seen = 1'b1;
                        end
                        csvt_pkg::ChLf: begin
                            end_field();
                            end_record();
                        end
                        default: append_unit(cu);
                    endcase
                end
            end
        end
        tokens_due.push_back(next_tok);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("token %0d %s: expected 0x%0h, got 0x%0h", n_checked, name, want, got);
            n_errors++;
        end
    endfunction

    function void check_token(csvt_pkg::t_result got);
        csvt_pkg::t_result want;
        if (tokens_due.size() == 0) begin
            $error("token %0d arrived with none outstanding", n_checked);
            n_errors++;
        end else begin
            want = tokens_due.pop_front();
            compare_field("char_valid", 16'(want.char_valid), 16'(got.char_valid));
            compare_field("out_char", want.out_char, got.out_char);
            compare_field("field_end", 16'(want.field_end), 16'(got.field_end));
            compare_field("record_end", 16'(want.record_end), 16'(got.record_end));
            compare_field("record_blank", 16'(want.record_blank), 16'(got.record_blank));
            compare_field("column_index", 16'(want.column_index), 16'(got.column_index));
        end
        n_checked++;
    endfunction
endclass

module csv_record_tokenizer_tb;
    import csvt_pkg::*;

    localparam int MaxColumns    = MaxColumnsDef;
    localparam int RandomUnits   = 1650;
    localparam int WatchdogLimit = 2000;
    localparam int TailCycles    = 20;

    // Whitespace code units other than CR and LF, which end records outside quotes.
    localparam logic [15:0] SpaceUnits [23] = '{
        16'h0009, 16'h000B, 16'h000C, 16'h0020, 16'h0085, 16'h00A0, 16'h1680,
        16'h2000, 16'h2001, 16'h2002, 16'h2003, 16'h2004, 16'h2005, 16'h2006,
        16'h2007, 16'h2008, 16'h2009, 16'h200A, 16'h2028, 16'h2029, 16'h202F,
        16'h205F, 16'h3000
    };
    // Units just outside the whitespace ranges: they must count as record content.
    localparam logic [15:0] NearSpaceUnits [20] = '{
        16'h0008, 16'h000E, 16'h001F, 16'h0021, 16'h0084, 16'h0086, 16'h009F,
        16'h00A1, 16'h167F, 16'h1681, 16'h1FFF, 16'h200B, 16'h2027, 16'h202A,
        16'h202E, 16'h2030, 16'h205E, 16'h2060, 16'h2FFF, 16'h3001
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    csvt_in_if  in_if ();
    csvt_out_if out_if ();

    csv_record_tokenizer #(
        .MAX_COLUMNS(MaxColumns)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    csv_token_scoreboard sb;

    bit gap_enabled   = 1'b1;  // insert idle cycles between input transfers
    bit stall_enabled = 1'b1;  // drop ready on the token channel at random
    int units_sent    = 0;
    int idle_cycles   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Pause length: mostly short, now and then long.
    function automatic int pause_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    // Field content outside quotes: never a quote, comma, CR or LF.
    function automatic logic [15:0] pick_text_unit();
        logic [15:0] u;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: u = 16'($urandom_range(16'h0023, 16'h007E));
            4, 5:       u = SpaceUnits[$urandom_range(0, 22)];
            6:          u = NearSpaceUnits[$urandom_range(0, 19)];
            default:    u = 16'($urandom());
        endcase
        if (u == ChQuote || u == ChComma || u == ChCr || u == ChLf) u = 16'h005A;
        return u;
    endfunction

    // Present one item and hold it until the transfer completes. Keep valid high
    // across back-to-back items so it is never lowered and raised in one step.
    task automatic send_unit(input logic [15:0] cu, input logic eot);
        int gap;
        gap = (gap_enabled && $urandom_range(0, 99) >= 55) ? pause_length() : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.code_unit   <= cu;
        in_if.end_of_text <= eot;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        units_sent++;
    endtask

    // One field of a record, in one of several shapes.
    task automatic send_field(input bit sparse);
        int r;
        int n;
        r = sparse ? ($urandom_range(0, 99) < 70 ? 80 : $urandom_range(0, 99))
                   : $urandom_range(0, 99);
        if (r < 35) begin
            // plain text
            n = $urandom_range(1, 6);
            repeat (n) send_unit(pick_text_unit(), 1'b0);
        end else if (r < 60 || (r >= 85 && r < 93)) begin
            // quoted section, possibly opened in mid-field and followed by more text
            if (r >= 85) send_unit(pick_text_unit(), 1'b0);
            send_unit(ChQuote, 1'b0);
            n = $urandom_range(0, 5);
            repeat (n) begin
                case ($urandom_range(0, 9))
                    6: send_unit(ChComma, 1'b0);
                    7: send_unit(ChCr, 1'b0);
                    8: send_unit(ChLf, 1'b0);
                    9: begin
                        send_unit(ChQuote, 1'b0);
                        send_unit(ChQuote, 1'b0);
                    end
                    default: send_unit(pick_text_unit(), 1'b0);
                endcase
            end
            send_unit(ChQuote, 1'b0);
            if ($urandom_range(0, 9) == 0) send_unit(pick_text_unit(), 1'b0);
        end else if (r < 75) begin
            // whitespace only
            n = $urandom_range(1, 3);
            repeat (n) send_unit(SpaceUnits[$urandom_range(0, 22)], 1'b0);
        end else if (r >= 93) begin
            // raw noise: any unit, structural ones included
            n = $urandom_range(1, 4);
            repeat (n) send_unit(16'($urandom()), 1'b0);
        end
        // anything else leaves the field empty
    endtask

    // One record: a list of fields and a terminator. Wide records push the
    // column counter past its limit.
    task automatic send_record(input bit force_wide);
        int nfields;
        int r;
        bit wide;
        r = $urandom_range(0, 99);
        wide = force_wide || r >= 98;
        if (wide) nfields = $urandom_range(MaxColumns, MaxColumns + 14);
        else if (r < 85) nfields = $urandom_range(1, 4);
        else nfields = $urandom_range(5, 12);

        for (int f = 0; f < nfields; f++) begin
            if (f > 0) send_unit(ChComma, 1'b0);
            send_field(wide);
        end

        r = $urandom_range(0, 99);
        if (r < 30) begin
            send_unit(ChLf, 1'b0);
        end else if (r < 55) begin
            send_unit(ChCr, 1'b0);
            send_unit(ChLf, 1'b0);
        end else if (r < 70) begin
            send_unit(ChCr, 1'b0);
        end else if (r < 85) begin
            send_unit(16'($urandom()), 1'b1);
        end else if (r < 92) begin
            // CRLF then an empty line
            send_unit(ChCr, 1'b0);
            send_unit(ChLf, 1'b0);
            send_unit(ChLf, 1'b0);
        end else begin
            send_unit(16'($urandom()), 1'b1);
            send_unit(16'($urandom()), 1'b1);
        end
    endtask

    // Pace the token channel: runs of ready broken by stalls of random length.
    initial begin : sink_pacing
        int run_left;
        run_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!stall_enabled) begin
                out_if.ready <= 1'b1;
                run_left = 0;
            end else if (run_left > 0) begin
                run_left--;
            end else if (out_if.ready && $urandom_range(0, 99) < 35) begin
                out_if.ready <= 1'b0;
                run_left = pause_length() - 1;
            end else begin
                out_if.ready <= 1'b1;
                run_left = $urandom_range(0, 10);
            end
        end
    end

    // Observe both channels at each edge: feed accepted input to the predictor
    // first, then check the accepted token. Drop the run if nothing moves for
    // too long.
    always @(posedge i_clk) begin : monitor
        csvt_pkg::t_result got;
        bit moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (in_if.valid && in_if.ready) begin
                sb.note_unit(in_if.code_unit, in_if.end_of_text);
                moved = 1'b1;
            end
            if (out_if.valid && out_if.ready) begin
                got.char_valid   = out_if.char_valid;
                got.out_char     = out_if.out_char;
                got.field_end    = out_if.field_end;
                got.record_end   = out_if.record_end;
                got.record_blank = out_if.record_blank;
                got.column_index = out_if.column_index;
                sb.check_token(got);
                moved = 1'b1;
            end
            if (moved) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WatchdogLimit) begin
                    $display("watchdog: no transfer for %0d cycles, %0d tokens outstanding",
                             idle_cycles, sb.tokens_due.size());
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        sb = new(MaxColumns);
        in_if.valid       <= 1'b0;
        in_if.code_unit   <= '0;
        in_if.end_of_text <= 1'b0;
        i_rst_n           <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: commas and quotes, escaped quote, quote closing before text,
        // CR then swallowed LF, empty line, field extremes, quote in mid-field,
        // end marker inside quotes, on an empty state, after an empty quoted
        // field, after a CR, and after a lone comma.
        send_unit(16'h0061, 1'b0);
        send_unit(ChComma, 1'b0);
        send_unit(ChQuote, 1'b0);
        send_unit(ChComma, 1'b0);
        send_unit(ChQuote, 1'b0);
        send_unit(ChQuote, 1'b0);
        send_unit(ChQuote, 1'b0);
        send_unit(16'h0062, 1'b0);
        send_unit(ChCr, 1'b0);
        send_unit(ChLf, 1'b0);
        send_unit(ChLf, 1'b0);
        send_unit(16'h3000, 1'b0);
        send_unit(16'hFFFF, 1'b0);
        send_unit(16'h0000, 1'b0);
        send_unit(ChQuote, 1'b0);
        send_unit(16'h0000, 1'b1);
        send_unit(16'h0000, 1'b1);
        send_unit(ChQuote, 1'b0);
        send_unit(ChQuote, 1'b0);
        send_unit(16'h0000, 1'b1);
        send_unit(16'h0020, 1'b0);
        send_unit(ChCr, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        send_unit(ChComma, 1'b0);
        send_unit(16'hFFFF, 1'b1);

        // Random records; the first is wide enough to saturate the column index.
        // Switch idling per record so some stretches run at full rate.
        send_record(1'b1);
        while (units_sent < RandomUnits + 25) begin
            gap_enabled   = ($urandom_range(0, 3) != 0);
            stall_enabled = ($urandom_range(0, 3) != 0);
            send_record(1'b0);
        end
        in_if.valid <= 1'b0;

        // Drain outstanding tokens, then hold a while to catch strays.
        while (sb.tokens_due.size() != 0) @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);

        $display("run covered %0d code units and %0d end markers; %0d tokens checked",
                 sb.n_units, sb.n_eot, sb.n_checked);
        $display("%0d records closed (%0d blank), %0d escaped quotes, %0d saturated fields",
                 sb.n_records, sb.n_blank, sb.n_escaped, sb.n_saturated);
        if (sb.n_errors == 0 && sb.tokens_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
